/* rtl/adcq_pkg.sv */
// Shared constants, types and a helper function for the ideal ADC quantiser.
package adcq_pkg;

  localparam int CODE_W      = 16;
  localparam int DT_W        = 16;
  localparam int DELAY_W     = 24;
  localparam int RES_W       = 5;
  localparam int WAIT_W      = 32;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;
  localparam int MAX_BITS_DEF = 16;
  localparam int VOLT_W_DEF  = 16;
  localparam int VOLT_W_MAX  = 32;

  // Divider operand widths, sized for the widest supported voltage.
  localparam int DIVR_W = VOLT_W_MAX + 1;
  localparam int DIVD_W = VOLT_W_MAX + CODE_W + 1;

  localparam int Q_DEPTH = 2;

  localparam logic [RES_W-1:0]   RES_BITS_RST = RES_W'(8);
  localparam logic [DELAY_W-1:0] DELAY_RST    = DELAY_W'(1000);

  // Register indexes, taken from paddr[2].
  localparam logic REG_RES_BITS = 1'b0;
  localparam logic REG_DELAY    = 1'b1;

  // One word handed from the front end to the back end.
  typedef struct packed {
    logic                direct;
    logic [CODE_W-1:0]   code;
    logic [DT_W-1:0]     dt;
    logic [DIVD_W-1:0]   dividend;
    logic [DIVR_W-1:0]   divisor;
  } q_item_t;

  // Settings that the back end needs from the register file.
  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               mask_we;
    logic [CODE_W-1:0]  mask;
  } cfg_t;

  function automatic logic [CODE_W-1:0] max_code_f(input logic [RES_W-1:0] bits);
    logic [CODE_W:0] one_sh;
    one_sh = (CODE_W + 1)'(1) << bits;
    return CODE_W'(one_sh - (CODE_W + 1)'(1));
  endfunction

endpackage

/* rtl/adcq_if.sv */
// Valid/ready channel interfaces for the sample and result words.
interface adcq_in_if #(
  parameter int VW = adcq_pkg::VOLT_W_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VW-1:0]          input_mv;
  logic signed [VW-1:0]          ref_high_mv;
  logic signed [VW-1:0]          ref_low_mv;
  logic [adcq_pkg::DT_W-1:0]     elapsed_us;

  modport source (output valid, input_mv, ref_high_mv, ref_low_mv, elapsed_us, input ready);
  modport sink   (input valid, input_mv, ref_high_mv, ref_low_mv, elapsed_us, output ready);
endinterface

interface adcq_out_if;
  logic                          valid;
  logic                          ready;
  logic [adcq_pkg::CODE_W-1:0]   code;
  logic                          busy_res;

  modport source (output valid, code, busy_res, input ready);
  modport sink   (input valid, code, busy_res, output ready);
endinterface

/* rtl/adcq_front.sv */
// Front end: takes a sample word, sorts out the clamped cases and forms the divider operands.
module adcq_front #(
  parameter int VOLT_WIDTH = adcq_pkg::VOLT_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  adcq_in_if.sink                    in_ch,
  input  logic [adcq_pkg::CODE_W-1:0] max_code,
  output logic                       q_push,
  output adcq_pkg::q_item_t          q_item,
  input  logic                       q_full
);
  import adcq_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIFF = 4'b0010,
    F_MUL  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic signed [VOLT_WIDTH-1:0] vin_r, vhi_r, vlo_r;
  logic [DT_W-1:0]              dt_r;
  logic [VOLT_WIDTH-1:0]        num_r, den_r;
  logic                         direct_r;
  logic [CODE_W-1:0]            code_r;
  logic [VOLT_WIDTH+CODE_W-1:0] prod_r;

  assign in_ch.ready = (state_r == F_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_ch.valid) state_nxt = F_DIFF;
      F_DIFF: state_nxt = F_MUL;
      F_MUL:  state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        vin_r <= in_ch.input_mv;
        vhi_r <= in_ch.ref_high_mv;
        vlo_r <= in_ch.ref_low_mv;
        dt_r  <= in_ch.elapsed_us;
      end
      F_DIFF: begin
        // Both differences lie in 0 .. 2^VOLT_WIDTH-1 whenever they are used.
        num_r <= VOLT_WIDTH'(vin_r - vlo_r);
        den_r <= VOLT_WIDTH'(vhi_r - vlo_r);
        if (vhi_r <= vlo_r || vin_r <= vlo_r) begin
          direct_r <= 1'b1;
          code_r   <= '0;
        end else if (vin_r >= vhi_r) begin
          direct_r <= 1'b1;
          code_r   <= max_code;
        end else begin
          direct_r <= 1'b0;
          code_r   <= '0;
        end
      end
      F_MUL: prod_r <= num_r * max_code;
      default: ;
    endcase
  end

  assign q_push          = (state_r == F_PUSH);
  assign q_item.direct   = direct_r;
  assign q_item.code     = code_r;
  assign q_item.dt       = dt_r;
  assign q_item.dividend = DIVD_W'({prod_r, 1'b0}) + DIVD_W'(den_r);
  assign q_item.divisor  = DIVR_W'({den_r, 1'b0});

endmodule

/* rtl/adcq_fifo.sv */
// Short queue that decouples the front end from the back end.
module adcq_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  adcq_pkg::q_item_t wr_item,
  output logic              full,
  input  logic              pop,
  output adcq_pkg::q_item_t rd_item,
  output logic              empty
);
  import adcq_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_item_t          mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

/* rtl/adcq_back.sv */
// Back end: shift-subtract divider, settling-delay tracker and result register.
module adcq_back #(
  parameter int MAX_BITS = adcq_pkg::MAX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  adcq_pkg::q_item_t q_item,
  output logic              q_pop,
  input  adcq_pkg::cfg_t    cfg,
  adcq_out_if.source        out_ch
);
  import adcq_pkg::*;

  localparam int CNT_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_DIV  = 5'b00010,
    B_EVAL = 5'b00100,
    B_CMP  = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t state_r;

  logic [DIVR_W-1:0]   rem_r, div_r;
  logic [MAX_BITS-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [DT_W-1:0]     dt_r;
  logic [CODE_W-1:0]   target_r;

  logic [CODE_W-1:0]   held_r, wcode_r;
  logic                waiting_r;
  logic [WAIT_W-1:0]   wait_r;

  logic                out_valid_r, out_busy_r;
  logic [CODE_W-1:0]   out_code_r;

  logic [DIVR_W:0]     trial;
  logic                ge;
  logic [DIVR_W-1:0]   rem_nxt;
  logic                restart;
  logic [WAIT_W-1:0]   wait_base;
  logic [WAIT_W:0]     wait_sum;
  logic                out_free;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    trial   = {rem_r, lo_r[MAX_BITS-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? DIVR_W'(trial - {1'b0, div_r}) : DIVR_W'(trial);
    lo_nxt  = MAX_BITS'({lo_r, ge});
  end

  always_comb begin
    restart   = !waiting_r || (wcode_r != target_r);
    wait_base = restart ? '0 : wait_r;
    wait_sum  = {1'b0, wait_base} + (WAIT_W + 1)'(dt_r);
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      held_r      <= '0;
      wcode_r     <= '0;
      waiting_r   <= 1'b0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In B_OUT a taken word is replaced by the next one below.
      if (out_valid_r && out_ch.ready && state_r != B_OUT) out_valid_r <= 1'b0;
      if (cfg.mask_we) held_r <= held_r & cfg.mask;

      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            dt_r <= q_item.dt;
            if (q_item.direct) begin
              target_r <= q_item.code;
              state_r  <= B_EVAL;
            end else begin
              // The quotient is known to fit MAX_BITS bits, so the upper
              // part of the dividend already lies below the divisor.
              rem_r   <= DIVR_W'(q_item.dividend >> MAX_BITS);
              lo_r    <= q_item.dividend[MAX_BITS-1:0];
              div_r   <= q_item.divisor;
              cnt_r   <= CNT_W'(MAX_BITS - 1);
              state_r <= B_DIV;
            end
          end
        end
        B_DIV: begin
          rem_r <= rem_nxt;
          lo_r  <= lo_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            target_r <= CODE_W'(lo_nxt);
            state_r  <= B_EVAL;
          end
        end
        B_EVAL: begin
          if (target_r == held_r) begin
            waiting_r <= 1'b0;
            wait_r    <= '0;
            state_r   <= B_OUT;
          end else if (cfg.delay == '0) begin
            held_r    <= target_r;
            waiting_r <= 1'b0;
            wait_r    <= '0;
            state_r   <= B_OUT;
          end else begin
            waiting_r <= 1'b1;
            wcode_r   <= target_r;
            wait_r    <= wait_sum[WAIT_W] ? '1 : wait_sum[WAIT_W-1:0];
            state_r   <= B_CMP;
          end
        end
        B_CMP: begin
          if (wait_r >= WAIT_W'(cfg.delay)) begin
            held_r    <= wcode_r;
            waiting_r <= 1'b0;
            wait_r    <= '0;
          end
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_OUT && out_free) begin
      out_code_r <= held_r;
      out_busy_r <= waiting_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.code     = out_code_r;
  assign out_ch.busy_res = out_busy_r;

endmodule

/* rtl/ideal_adc_quantizer_with_delay.sv */
// Top level of the ideal ADC quantiser with settling delay: registers, front end, queue, back end.
//
// Each input word is one simulation tick and yields exactly one result word holding the
// settled code and a busy flag. The front end takes a word, steps it through its difference,
// multiply and push states and places it in a two-entry queue, stalling while the queue is
// full; the back end works on one word at a time with its shift-subtract divider that produces
// one code bit per cycle, while the front end can take further words as long as the queue has room.
// Clamped inputs and inverted references skip the divider in the back end. The two registers
// sit at byte addresses 0 (resolution, clamped to 1..MAX_BITS) and 4 (settling delay in
// microseconds); write them only while no word is in flight.
module ideal_adc_quantizer_with_delay #(
  parameter int MAX_BITS   = adcq_pkg::MAX_BITS_DEF,
  parameter int VOLT_WIDTH = adcq_pkg::VOLT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  adcq_in_if.sink                     in_ch,
  adcq_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adcq_pkg::APB_AW-1:0] paddr,
  input  logic [adcq_pkg::APB_DW-1:0] pwdata,
  output logic [adcq_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import adcq_pkg::*;

  logic [RES_W-1:0]   res_bits_r;
  logic [DELAY_W-1:0] delay_r;
  logic               wr_en;
  logic [RES_W-1:0]   res_wr;
  logic [CODE_W-1:0]  max_code;
  cfg_t               cfg;

  logic    q_push, q_full, q_pop, q_empty;
  q_item_t q_wr_item, q_rd_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    res_wr = pwdata[RES_W-1:0];
    if (res_wr == '0) res_wr = RES_W'(1);
    else if (res_wr > RES_W'(MAX_BITS)) res_wr = RES_W'(MAX_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_bits_r <= RES_BITS_RST;
      delay_r    <= DELAY_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_RES_BITS: res_bits_r <= res_wr;
        REG_DELAY:    delay_r    <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RES_BITS: prdata = APB_DW'(res_bits_r);
      REG_DELAY:    prdata = APB_DW'(delay_r);
      default:      prdata = '0;
    endcase
  end

  assign max_code    = max_code_f(res_bits_r);
  // A resolution write trims the held code to the new width.
  assign cfg.delay   = delay_r;
  assign cfg.mask_we = wr_en && (paddr[2] == REG_RES_BITS);
  assign cfg.mask    = max_code_f(res_wr);

  adcq_front #(
    .VOLT_WIDTH(VOLT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .max_code (max_code),
    .q_push   (q_push),
    .q_item   (q_wr_item),
    .q_full   (q_full)
  );

  adcq_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  adcq_back #(
    .MAX_BITS(MAX_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_rd_item),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .out_ch  (out_ch)
  );

endmodule
